@@ src/biquad_direct_form_two_filter_defines.svh @@
// Assertion macros for the biquad filter.
`ifndef BIQUAD_DIRECT_FORM_TWO_FILTER_DEFINES_SVH
`define BIQUAD_DIRECT_FORM_TWO_FILTER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define BQ_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("bq assertion failed");
// next-cycle implication
`define BQ_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("bq assertion failed");
`else
`define BQ_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define BQ_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

@@ src/bqdf2_pkg.sv @@
package bqdf2_pkg;

    localparam int SAMPLE_BITS_DEF = 16;
    localparam int COEF_BITS_DEF   = 24;
    localparam int STATE_BITS_DEF  = 48;

    localparam int STATE_FRAC  = 8;
    localparam int OUT_BITS    = 26;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;
    localparam int CFG_IDX_W   = 3;
    localparam int PC_W        = 4;

    // Q2.22 reset coefficients: 0.2 Hz high-pass at 125 Hz
    localparam logic signed [31:0] RST_B0 = 32'sd4164525;
    localparam logic signed [31:0] RST_B1 = -32'sd8329049;
    localparam logic signed [31:0] RST_B2 = 32'sd4164525;
    localparam logic signed [31:0] RST_A1 = -32'sd8329049;
    localparam logic signed [31:0] RST_A2 = 32'sd4135164;

    typedef enum logic [CFG_IDX_W-1:0] {
        CI_B0 = 3'd0,
        CI_B1 = 3'd1,
        CI_B2 = 3'd2,
        CI_A1 = 3'd3,
        CI_A2 = 3'd4
    } t_cfg_idx;

    typedef enum logic [2:0] {CS_B0, CS_B1, CS_B2, CS_A1, CS_A2} t_coef_sel;
    typedef enum logic [1:0] {SS_D1, SS_D2, SS_W} t_src_sel;
    typedef enum logic [1:0] {PO_NOP, PO_LDH, PO_ADDL} t_prod_op;
    typedef enum logic [2:0] {AO_NOP, AO_LDX, AO_SUB, AO_ADD, AO_LDP} t_acc_op;
    typedef enum logic [1:0] {JC_NEVER, JC_NO_START, JC_OUT_BUSY, JC_ALWAYS} t_jcond;

    typedef struct packed {
        t_coef_sel       coef;
        t_src_sel        src;
        logic            mul_hi;
        t_prod_op        prod;
        t_acc_op         acc;
        logic            wsat;
        logic            emit;
        t_jcond          jc;
        logic [PC_W-1:0] tgt;
    } t_ucode;

endpackage

@@ src/biquad_direct_form_two_filter.sv @@
// Biquad IIR section, direct form II, one shared multiplier run by a microcoded sequencer.
// A new item is accepted only in the idle step, after the last one has been emitted. Each item takes
// ten multiplier passes (two half-word partials per tap), two drain steps, output check, emit and
// idle accept step; a stalled output adds its wait.
// Reset (synchronous, active low): delay line cleared, coefficients set to the
// 0.2 Hz high-pass, output empty, sequencer idle.
`include "biquad_direct_form_two_filter_defines.svh"

module biquad_direct_form_two_filter #(
    parameter int SAMPLE_BITS = bqdf2_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_BITS   = bqdf2_pkg::COEF_BITS_DEF,
    parameter int STATE_BITS  = bqdf2_pkg::STATE_BITS_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_s_axis_tvalid,
    output logic                                    o_s_axis_tready,
    // sample_in
    input  logic [((SAMPLE_BITS + 7) / 8) * 8-1:0]  i_s_axis_tdata,
    output logic                                    o_m_axis_tvalid,
    input  logic                                    i_m_axis_tready,
    // filtered_out
    output logic [bqdf2_pkg::OUT_TDATA_W-1:0]       o_m_axis_tdata,
    input  logic                                    i_cfg_we,
    input  logic [bqdf2_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [COEF_BITS-1:0]                    i_cfg_data
);
    import bqdf2_pkg::*;

    logic signed [COEF_BITS-1:0] r_b0, r_b1, r_b2, r_a1, r_a2;
    logic                        r_out_valid;
    logic signed [OUT_BITS-1:0]  r_out;
    logic signed [OUT_BITS-1:0]  s_result;
    logic                        s_start, s_out_busy;
    t_ucode                      s_ctl;

    assign s_start    = i_s_axis_tvalid && o_s_axis_tready;
    assign s_out_busy = r_out_valid && !i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b0 <= COEF_BITS'(RST_B0);
            r_b1 <= COEF_BITS'(RST_B1);
            r_b2 <= COEF_BITS'(RST_B2);
            r_a1 <= COEF_BITS'(RST_A1);
            r_a2 <= COEF_BITS'(RST_A2);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CI_B0:   r_b0 <= i_cfg_data;
                CI_B1:   r_b1 <= i_cfg_data;
                CI_B2:   r_b2 <= i_cfg_data;
                CI_A1:   r_a1 <= i_cfg_data;
                CI_A2:   r_a2 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    bqdf2_useq u_useq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (s_start),
        .i_out_busy (s_out_busy),
        .o_ctl      (s_ctl)
    );

    bqdf2_dpath #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEF_BITS   (COEF_BITS),
        .STATE_BITS  (STATE_BITS)
    ) u_dpath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (s_ctl),
        .i_start   (s_start),
        .i_sample  (i_s_axis_tdata[SAMPLE_BITS-1:0]),
        .i_coef_b0 (r_b0),
        .i_coef_b1 (r_b1),
        .i_coef_b2 (r_b2),
        .i_coef_a1 (r_a1),
        .i_coef_a2 (r_a2),
        .o_result  (s_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_ctl.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_ctl.emit) begin
            r_out <= s_result;
        end
    end

    assign o_s_axis_tready = (s_ctl.jc == JC_NO_START);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(OUT_TDATA_W - OUT_BITS){1'b0}}, r_out};

    `BQ_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, s_start, !o_s_axis_tready)
    `BQ_ASSERT_IMP(a_no_overwrite, i_clk, i_rst_n, s_ctl.emit && r_out_valid, i_m_axis_tready)
    `BQ_ASSERT_IMP(a_no_emit_idle, i_clk, i_rst_n, s_ctl.emit, !o_s_axis_tready)

endmodule

@@ src/bqdf2_useq.sv @@
module bqdf2_useq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_out_busy,
    output bqdf2_pkg::t_ucode o_ctl
);
    import bqdf2_pkg::*;

    logic [PC_W-1:0] r_pc, n_pc;
    t_ucode          s_uw;
    logic            s_take;

    // microprogram: multiply issue -> product build -> accumulate, one step apart
    function automatic t_ucode f_rom(input logic [PC_W-1:0] pc);
        t_ucode u;
        u = '0;
        unique case (pc)
            4'd0: begin u.jc = JC_NO_START; u.tgt = 4'd0; end
            4'd1: begin u.coef = CS_A1; u.src = SS_D1; u.mul_hi = 1'b1; u.acc = AO_LDX; end
            4'd2: begin u.coef = CS_A1; u.src = SS_D1; u.prod = PO_LDH; end
            4'd3: begin u.coef = CS_A2; u.src = SS_D2; u.mul_hi = 1'b1; u.prod = PO_ADDL; end
            4'd4: begin
                u.coef = CS_A2; u.src = SS_D2; u.prod = PO_LDH; u.acc = AO_SUB;
            end
            4'd5: begin u.coef = CS_B1; u.src = SS_D1; u.mul_hi = 1'b1; u.prod = PO_ADDL; end
            4'd6: begin
                u.coef = CS_B1; u.src = SS_D1; u.prod = PO_LDH; u.acc = AO_SUB;
            end
            4'd7: begin
                u.coef = CS_B2; u.src = SS_D2; u.mul_hi = 1'b1; u.prod = PO_ADDL;
                u.wsat = 1'b1;
            end
            4'd8: begin
                u.coef = CS_B2; u.src = SS_D2; u.prod = PO_LDH; u.acc = AO_LDP;
            end
            4'd9: begin u.coef = CS_B0; u.src = SS_W; u.mul_hi = 1'b1; u.prod = PO_ADDL; end
            4'd10: begin
                u.coef = CS_B0; u.src = SS_W; u.prod = PO_LDH; u.acc = AO_ADD;
            end
            4'd11: begin u.prod = PO_ADDL; end
            4'd12: begin u.acc = AO_ADD; end
            4'd13: begin u.jc = JC_OUT_BUSY; u.tgt = 4'd13; end
            4'd14: begin u.emit = 1'b1; u.jc = JC_ALWAYS; u.tgt = 4'd0; end
            default: begin u.jc = JC_ALWAYS; u.tgt = 4'd0; end
        endcase
        return u;
    endfunction

    assign s_uw = f_rom(r_pc);

    always_comb begin
        unique case (s_uw.jc)
            JC_NEVER:    s_take = 1'b0;
            JC_NO_START: s_take = !i_start;
            JC_OUT_BUSY: s_take = i_out_busy;
            JC_ALWAYS:   s_take = 1'b1;
            default:     s_take = 1'b1;
        endcase
        n_pc = s_take ? s_uw.tgt : r_pc + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= '0;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_ctl = s_uw;

endmodule

@@ src/bqdf2_dpath.sv @@
module bqdf2_dpath #(
    parameter int SAMPLE_BITS = bqdf2_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_BITS   = bqdf2_pkg::COEF_BITS_DEF,
    parameter int STATE_BITS  = bqdf2_pkg::STATE_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  bqdf2_pkg::t_ucode                    i_ctl,
    input  logic                                 i_start,
    input  logic [SAMPLE_BITS-1:0]               i_sample,
    input  logic signed [COEF_BITS-1:0]          i_coef_b0,
    input  logic signed [COEF_BITS-1:0]          i_coef_b1,
    input  logic signed [COEF_BITS-1:0]          i_coef_b2,
    input  logic signed [COEF_BITS-1:0]          i_coef_a1,
    input  logic signed [COEF_BITS-1:0]          i_coef_a2,
    output logic signed [bqdf2_pkg::OUT_BITS-1:0] o_result
);
    import bqdf2_pkg::*;

    localparam int HALF      = STATE_BITS / 2;
    localparam int HI_W      = STATE_BITS - HALF;
    localparam int OP_W      = HI_W + 1;
    localparam int MUL_W     = COEF_BITS + OP_W;
    localparam int PROD_W    = COEF_BITS + STATE_BITS;
    localparam int COEF_FRAC = COEF_BITS - 2;
    localparam int SH_W      = PROD_W - COEF_FRAC;
    localparam int ACC_W     = STATE_BITS + 4;
    localparam int X_W       = SAMPLE_BITS + STATE_FRAC;

    localparam logic signed [ACC_W-1:0] W_MAX =
        {{(ACC_W - STATE_BITS + 1){1'b0}}, {(STATE_BITS - 1){1'b1}}};
    localparam logic signed [ACC_W-1:0] W_MIN = ~W_MAX;
    localparam logic signed [ACC_W-1:0] Y_MAX =
        {{(ACC_W - OUT_BITS + 1){1'b0}}, {(OUT_BITS - 1){1'b1}}};
    localparam logic signed [ACC_W-1:0] Y_MIN = ~Y_MAX;

    logic [SAMPLE_BITS-1:0]         r_x;
    logic signed [STATE_BITS-1:0]   r_d1, r_d2, r_w;
    logic signed [MUL_W-1:0]        r_mul;
    logic signed [PROD_W-1:0]       r_prod;
    logic signed [ACC_W-1:0]        r_acc;

    logic signed [COEF_BITS-1:0]    s_coef;
    logic signed [STATE_BITS-1:0]   s_st;
    logic signed [OP_W-1:0]         s_op;
    logic signed [MUL_W-1:0]        n_mul;
    logic signed [PROD_W-1:0]       s_mul_x;
    logic signed [ACC_W-1:0]        s_sh_x, s_x;
    logic signed [STATE_BITS-1:0]   s_w_sat;

    always_comb begin
        unique case (i_ctl.coef)
            CS_B0:   s_coef = i_coef_b0;
            CS_B1:   s_coef = i_coef_b1;
            CS_B2:   s_coef = i_coef_b2;
            CS_A1:   s_coef = i_coef_a1;
            CS_A2:   s_coef = i_coef_a2;
            default: s_coef = '0;
        endcase
        unique case (i_ctl.src)
            SS_D1:   s_st = r_d1;
            SS_D2:   s_st = r_d2;
            SS_W:    s_st = r_w;
            default: s_st = '0;
        endcase
    end

    // state word split: signed upper half, unsigned lower half
    assign s_op = i_ctl.mul_hi ? {s_st[STATE_BITS-1], s_st[STATE_BITS-1:HALF]}
                               : {{(OP_W - HALF){1'b0}}, s_st[HALF-1:0]};
    assign n_mul   = s_coef * s_op;
    assign s_mul_x = {{(PROD_W - MUL_W){r_mul[MUL_W-1]}}, r_mul};
    assign s_sh_x  = {{(ACC_W - SH_W){r_prod[PROD_W-1]}}, r_prod[PROD_W-1:COEF_FRAC]};
    assign s_x     = {{(ACC_W - X_W){1'b0}}, r_x, {STATE_FRAC{1'b0}}};

    always_comb begin
        if (r_acc > W_MAX) begin
            s_w_sat = W_MAX[STATE_BITS-1:0];
        end else if (r_acc < W_MIN) begin
            s_w_sat = W_MIN[STATE_BITS-1:0];
        end else begin
            s_w_sat = r_acc[STATE_BITS-1:0];
        end
        if (r_acc > Y_MAX) begin
            o_result = Y_MAX[OUT_BITS-1:0];
        end else if (r_acc < Y_MIN) begin
            o_result = Y_MIN[OUT_BITS-1:0];
        end else begin
            o_result = r_acc[OUT_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_mul <= n_mul;
        if (i_start) begin
            r_x <= i_sample;
        end
        unique case (i_ctl.prod)
            PO_LDH:  r_prod <= s_mul_x <<< HALF;
            PO_ADDL: r_prod <= r_prod + s_mul_x;
            default: r_prod <= r_prod;
        endcase
        unique case (i_ctl.acc)
            AO_LDX:  r_acc <= s_x;
            AO_SUB:  r_acc <= r_acc - s_sh_x;
            AO_ADD:  r_acc <= r_acc + s_sh_x;
            AO_LDP:  r_acc <= s_sh_x;
            default: r_acc <= r_acc;
        endcase
        if (i_ctl.wsat) begin
            r_w <= s_w_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d1 <= '0;
            r_d2 <= '0;
        end else if (i_ctl.emit) begin
            r_d2 <= r_d1;
            r_d1 <= r_w;
        end
    end

endmodule

@@ tb/biquad_df2_checker.sv @@
module biquad_df2_checker
    import bqdf2_pkg::*;
(
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_ready,
    input  logic [SAMPLE_BITS_DEF-1:0]     i_in_data,
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    input  logic [OUT_TDATA_W-1:0]         i_out_data,
    input  logic                           i_cfg_we,
    input  logic [CFG_IDX_W-1:0]           i_cfg_idx,
    input  logic [COEF_BITS_DEF-1:0]       i_cfg_data,
    output int                             o_fail_count,
    output int                             o_pending
);

    localparam int SAMPLE_BITS = SAMPLE_BITS_DEF;
    localparam int COEF_BITS   = COEF_BITS_DEF;
    localparam int STATE_BITS  = STATE_BITS_DEF;
    localparam int COEF_FRAC   = COEF_BITS - 2;

    typedef logic signed [COEF_BITS-1:0]  coef_t;
    typedef logic signed [STATE_BITS-1:0] state_t;
    typedef logic signed [OUT_BITS-1:0]   out_t;
    typedef logic signed [127:0]          wide_t;

    coef_t  coef [5];
    state_t delay_one;
    state_t delay_two;
    out_t   expected_filtered [$];

    function automatic wide_t scaled_product(input coef_t c, input state_t w);
        wide_t cw;
        wide_t ww;
        cw = c;
        ww = w;
        return (cw * ww) >>> COEF_FRAC;
    endfunction

    function automatic wide_t saturate(input wide_t v, input int bits);
        wide_t hi_lim;
        wide_t lo_lim;
        hi_lim = (wide_t'(1) <<< (bits - 1)) - 1;
        lo_lim = -hi_lim - 1;
        if (v > hi_lim) begin
            return hi_lim;
        end else if (v < lo_lim) begin
            return lo_lim;
        end
        return v;
    endfunction

    // one direct-form-II step; updates the delay line
    function automatic out_t filter_sample(input logic [SAMPLE_BITS-1:0] x);
        wide_t xw;
        wide_t w;
        wide_t y;
        xw = {{(128 - SAMPLE_BITS){1'b0}}, x};
        xw = xw <<< STATE_FRAC;
        w = xw - scaled_product(coef[CI_A1], delay_one)
               - scaled_product(coef[CI_A2], delay_two);
        w = saturate(w, STATE_BITS);
        y = scaled_product(coef[CI_B0], state_t'(w))
          + scaled_product(coef[CI_B1], delay_one)
          + scaled_product(coef[CI_B2], delay_two);
        y = saturate(y, OUT_BITS);
        delay_two = delay_one;
        delay_one = state_t'(w);
        return out_t'(y);
    endfunction

    task automatic report_mismatch(input string what);
        $display("checker: %s", what);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        out_t got;
        out_t want;
        if (!i_rst_n) begin
            coef[CI_B0] = RST_B0[COEF_BITS-1:0];
            coef[CI_B1] = RST_B1[COEF_BITS-1:0];
            coef[CI_B2] = RST_B2[COEF_BITS-1:0];
            coef[CI_A1] = RST_A1[COEF_BITS-1:0];
            coef[CI_A2] = RST_A2[COEF_BITS-1:0];
            delay_one = '0;
            delay_two = '0;
            expected_filtered.delete();
        end else begin
            if (i_cfg_we && i_cfg_idx <= CI_A2) begin
                coef[i_cfg_idx] = i_cfg_data;
            end
            if (i_out_valid && i_out_ready) begin
                got = i_out_data[OUT_BITS-1:0];
                if (expected_filtered.size() == 0) begin
                    report_mismatch($sformatf("unexpected item, filtered_out %0d", got));
                end else begin
                    want = expected_filtered.pop_front();
                    if (got !== want) begin
                        report_mismatch($sformatf("filtered_out got %0d expected %0d",
                                                  got, want));
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                expected_filtered.push_back(filter_sample(i_in_data));
            end
        end
        o_pending = expected_filtered.size();
    end

endmodule

@@ tb/tb_biquad_direct_form_two_filter.sv @@
module tb_biquad_direct_form_two_filter;
    import bqdf2_pkg::*;

    localparam int SAMPLE_BITS   = SAMPLE_BITS_DEF;
    localparam int COEF_BITS     = COEF_BITS_DEF;
    localparam int SAMPLE_TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int NUM_COEFS     = 5;
    localparam int NUM_PHASES    = 12;
    localparam int PHASE_ITEMS   = 138;
    localparam int SETTLE_CYCLES = 30;
    localparam int LIMIT_CYCLES  = 1000000;

    localparam logic [COEF_BITS-1:0] COEF_MAX = {1'b0, {(COEF_BITS-1){1'b1}}};
    localparam logic [COEF_BITS-1:0] COEF_MIN = {1'b1, {(COEF_BITS-1){1'b0}}};
    // 0.0134 0.0267 0.0134 / -1.6475 0.7009 low-pass
    localparam logic signed [COEF_BITS-1:0] LP_B0 = 24'sd56204;
    localparam logic signed [COEF_BITS-1:0] LP_B1 = 24'sd111988;
    localparam logic signed [COEF_BITS-1:0] LP_A1 = -24'sd6910116;
    localparam logic signed [COEF_BITS-1:0] LP_A2 = 24'sd2939789;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_s_axis_tvalid = 1'b0;
    logic                      o_s_axis_tready;
    logic [SAMPLE_TDATA_W-1:0] i_s_axis_tdata = '0;
    logic                      o_m_axis_tvalid;
    logic                      i_m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]    o_m_axis_tdata;
    logic                      i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]      i_cfg_idx = '0;
    logic [COEF_BITS-1:0]      i_cfg_data = '0;

    int fail_count;
    int pending_results;
    int src_idle_pct = 0;
    int snk_stall_pct = 0;

    logic [COEF_BITS-1:0] coef_set [NUM_COEFS];

    biquad_direct_form_two_filter u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data)
    );

    biquad_df2_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_s_axis_tvalid),
        .i_in_ready   (o_s_axis_tready),
        .i_in_data    (i_s_axis_tdata[SAMPLE_BITS-1:0]),
        .i_out_valid  (o_m_axis_tvalid),
        .i_out_ready  (i_m_axis_tready),
        .i_out_data   (o_m_axis_tdata),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending_results)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
    end

    initial begin
        #(8 * LIMIT_CYCLES);
        $display("tb: failure");
        $finish;
    end

    // entered and left at a falling edge; tvalid stays high between back-to-back items
    task automatic send_sample(input logic [SAMPLE_BITS-1:0] value);
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= value;
        do begin
            @(posedge i_clk);
        end while (!o_s_axis_tready);
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        i_s_axis_tvalid <= 1'b0;
        while (pending_results != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic load_coef_set();
        int i;
        for (i = 0; i < NUM_COEFS; i++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= t_cfg_idx'(i);
            i_cfg_data <= coef_set[i];
            @(negedge i_clk);
        end
        // out-of-range index, must be ignored
        i_cfg_idx  <= CFG_IDX_W'(NUM_COEFS + $urandom_range(2));
        i_cfg_data <= COEF_BITS'($urandom);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic pick_coef_set(input int ph);
        int i;
        case (ph)
            0, 11: begin
                coef_set[CI_B0] = LP_B0;
                coef_set[CI_B1] = LP_B1;
                coef_set[CI_B2] = LP_B0;
                coef_set[CI_A1] = LP_A1;
                coef_set[CI_A2] = LP_A2;
            end
            1: begin
                for (i = 0; i < NUM_COEFS; i++) coef_set[i] = COEF_MAX;
            end
            2: begin
                for (i = 0; i < NUM_COEFS; i++) coef_set[i] = COEF_MIN;
            end
            4: begin
                for (i = 0; i < NUM_COEFS; i++) coef_set[i] = '0;
            end
            5: begin
                coef_set[CI_B0] = COEF_MAX;
                coef_set[CI_B1] = COEF_MAX;
                coef_set[CI_B2] = COEF_MAX;
                coef_set[CI_A1] = COEF_MIN;
                coef_set[CI_A2] = COEF_MIN;
            end
            7: begin
                coef_set[CI_B0] = COEF_MIN;
                coef_set[CI_B1] = COEF_MIN;
                coef_set[CI_B2] = COEF_MIN;
                coef_set[CI_A1] = COEF_MAX;
                coef_set[CI_A2] = COEF_MAX;
            end
            9: begin
                coef_set[CI_B0] = RST_B0[COEF_BITS-1:0];
                coef_set[CI_B1] = RST_B1[COEF_BITS-1:0];
                coef_set[CI_B2] = RST_B2[COEF_BITS-1:0];
                coef_set[CI_A1] = RST_A1[COEF_BITS-1:0];
                coef_set[CI_A2] = RST_A2[COEF_BITS-1:0];
            end
            default: begin
                for (i = 0; i < NUM_COEFS; i++) coef_set[i] = COEF_BITS'($urandom);
            end
        endcase
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            0: begin
                src_idle_pct  = 0;
                snk_stall_pct = 0;
            end
            1: begin
                src_idle_pct  = 77;
                snk_stall_pct = 0;
            end
            2: begin
                src_idle_pct  = 0;
                snk_stall_pct = 77;
            end
            default: begin
                src_idle_pct  = 14;
                snk_stall_pct = 14;
            end
        endcase
    endtask

    // random (45%), with held values (steps), extremes and small values
    function automatic logic [SAMPLE_BITS-1:0] next_sample(input logic [SAMPLE_BITS-1:0] prev);
        int pick;
        pick = $urandom_range(99);
        if (pick < 45) begin
            return SAMPLE_BITS'($urandom);
        end else if (pick < 65) begin
            return prev;
        end else if (pick < 80) begin
            return pick[0] ? '1 : '0;
        end
        return SAMPLE_BITS'($urandom_range(255));
    endfunction

    initial begin
        logic [SAMPLE_BITS-1:0] sample;
        int ph;
        int n;
        int k;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset coefficients: extremes, steps, walking one
        set_idling(0);
        send_sample('0);
        send_sample('0);
        send_sample('1);
        send_sample('1);
        send_sample('1);
        send_sample('0);
        send_sample('1);
        send_sample('0);
        for (k = 0; k < SAMPLE_BITS; k++) send_sample(SAMPLE_BITS'(1) << k);
        drain_results();

        sample = '0;
        for (ph = 0; ph < NUM_PHASES; ph++) begin
            pick_coef_set(ph);
            load_coef_set();
            set_idling(ph % 4);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 2 && n == PHASE_ITEMS / 2) drain_results();
                sample = next_sample(sample);
                send_sample(sample);
            end
            drain_results();
        end

        if (fail_count == 0 && pending_results == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
